/* rtl/cfp_pkg.sv */
// Shared types and constants for the command frame parser.
// No dependencies.
package cfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    PH_SYNC  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD   = 3'd2,
    PH_ADDR  = 3'd3,
    PH_VAL   = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

endpackage

/* rtl/command_frame_parser_core.sv */
// Command frame parser: sync, length, command, address, value, checksum.
// Latency: a result appears in the cycle after its checksum byte is taken.
// Throughput: one byte per cycle. A waiting result stalls only a checksum byte.
// Reset: synchronous, active high; the parser waits for sync.
// The held command, address, value and running sum reset to zero.
// Depends on cfp_pkg.
module command_frame_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cmd_code,
  output logic [7:0] target_addr,
  output logic [7:0] data_value,
  output logic       checksum_ok
);
  import cfp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] declared_length, declared_length_next;
  logic [1:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_addr, held_addr_next;
  logic [7:0] held_value, held_value_next;
  logic       in_fire;
  logic       emit;
  logic [1:0] seen_inc;
  logic [7:0] sum_inc;

  assign in_ready = !out_valid || out_ready || (phase != PH_CHECK);
  assign in_fire  = in_valid && in_ready;
  assign seen_inc = bytes_seen + 2'd1;
  assign sum_inc  = running_sum + rx_byte;

  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    bytes_seen_next      = bytes_seen;
    running_sum_next     = running_sum;
    held_command_next    = held_command;
    held_addr_next       = held_addr;
    held_value_next      = held_value;
    if (in_fire) begin
      case (phase)
        PH_LEN: begin
          declared_length_next = rx_byte;
          bytes_seen_next      = 2'd0;
          running_sum_next     = 8'd0;
          phase_next           = PH_CMD;
        end
        PH_CMD: begin
          held_command_next = rx_byte;
          running_sum_next  = sum_inc;
          bytes_seen_next   = seen_inc;
          phase_next        = ({6'd0, seen_inc} < declared_length) ? PH_ADDR : PH_CHECK;
        end
        PH_ADDR: begin
          held_addr_next   = rx_byte;
          running_sum_next = sum_inc;
          bytes_seen_next  = seen_inc;
          phase_next       = ({6'd0, seen_inc} < declared_length) ? PH_VAL : PH_CHECK;
        end
        PH_VAL: begin
          held_value_next  = rx_byte;
          running_sum_next = sum_inc;
          bytes_seen_next  = seen_inc;
          phase_next       = PH_CHECK;
        end
        PH_CHECK: begin
          phase_next = PH_SYNC;
        end
        default: begin
          phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC;
        end
      endcase
    end
  end

  always_comb begin
    emit = in_fire && (phase == PH_CHECK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC;
      declared_length <= 8'd0;
      bytes_seen      <= 2'd0;
      running_sum     <= 8'd0;
      held_command    <= 8'd0;
      held_addr       <= 8'd0;
      held_value      <= 8'd0;
    end else begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      bytes_seen      <= bytes_seen_next;
      running_sum     <= running_sum_next;
      held_command    <= held_command_next;
      held_addr       <= held_addr_next;
      held_value      <= held_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_code    <= held_command;
      target_addr <= held_addr;
      data_value  <= held_value;
      checksum_ok <= (running_sum == rx_byte);
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result not presented after checksum byte");

  a_sync_to_len: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_SYNC && rx_byte == SYNC_BYTE) |=> (phase == PH_LEN))
    else $error("sync byte did not start a frame");

  a_len_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_LEN) |=> (running_sum == 8'd0 && bytes_seen == 2'd0))
    else $error("length byte did not clear frame sum");

  a_rose_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(phase) == PH_CHECK && $past(in_fire)))
    else $error("result appeared outside checksum byte");

  a_no_stall_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !emit)
    else $error("pending result overwritten");

endmodule
